>>> sv/mmh_pkg.sv
// Package for the heap-insert block: word types, controller states, sift kinds
// and the command/status structs between controller and datapath. No dependencies.
package mmh_pkg;

  typedef struct packed {
    logic        clear_first;
    logic [15:0] record_id;
    logic [15:0] new_key;
  } in_word_t;

  typedef struct packed {
    logic [10:0] entry_count;
    logic        overflow;
    logic [15:0] root_id;
    logic [15:0] root_key;
    logic [15:0] bottom_id;
    logic [15:0] bottom_key;
    logic [15:0] leftmost_id;
    logic [15:0] leftmost_key;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_WR, S_RD0, S_RD1, S_RD2, S_RD3, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    K_PAR, K_FIRST, K_GP
  } sift_kind_t;

  typedef struct packed {
    logic start;
    logic rd_anc;
    logic step;
    logic wr_final;
    logic rd_root;
    logic rd_last;
    logic rd_left;
    logic cap_root;
    logic cap_last;
    logic cap_left;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic start_ovf;
    logic start_cont;
    logic step_cont;
  } stat_t;

endpackage

>>> sv/mmh_dpath.sv
// Datapath of the heap-insert block: heap memory, moving record, sift index,
// count, mode register and result registers. Depends on mmh_pkg.
module mmh_dpath #(
  parameter int HEAP_DEPTH = 1024,
  parameter int KEY_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  mmh_pkg::in_word_t  in_word,
  input  mmh_pkg::cmd_t      cmd,
  output mmh_pkg::stat_t     stat,
  output mmh_pkg::out_word_t out_word
);
  import mmh_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int RW = 16 + KEY_BITS;

  logic [RW-1:0]       mem [HEAP_DEPTH];
  logic [RW-1:0]       q_r;
  logic                mode_r;
  logic [CW-1:0]       count_r;
  logic [AW-1:0]       n_r, n_nxt;
  logic [15:0]         id_r;
  logic [KEY_BITS-1:0] key_r;
  sift_kind_t          kind_r, kind_nxt;
  logic                less_r, less_nxt;
  logic                ovf_r;
  logic [31:0]         root_r, last_r, left_r;
  out_word_t           out_r;

  logic [31:0]         key_ext, qk32;
  logic [KEY_BITS-1:0] key_in, qk;
  logic [CW-1:0]       count_eff, last_w, smear;
  logic [AW:0]         n_w, par_w, gp_w, v_w;
  logic [AW-1:0]       anc, raddr;
  logic                lvl_odd, on_min, move;
  logic                step_cont;
  logic [31:0]         q_out;

  function automatic logic has_anc(input logic [AW-1:0] nx, input sift_kind_t k);
    if (k == K_GP) return {1'b0, nx} >= (AW+1)'(3);
    else return nx != '0;
  endfunction

  assign key_ext   = {16'b0, in_word.new_key};
  assign key_in    = key_ext[KEY_BITS-1:0];
  assign count_eff = in_word.clear_first ? '0 : count_r;
  assign stat.start_ovf  = (count_eff == CW'(HEAP_DEPTH));
  assign stat.start_cont = !stat.start_ovf && (count_eff != '0);
  assign stat.step_cont  = step_cont;

  assign n_w   = {1'b0, n_r};
  assign par_w = (n_w - (AW+1)'(1)) >> 1;
  assign gp_w  = (n_w - (AW+1)'(3)) >> 2;
  assign anc   = (kind_r == K_GP) ? gp_w[AW-1:0] : par_w[AW-1:0];
  assign v_w   = n_w + (AW+1)'(1);
  assign qk    = q_r[KEY_BITS-1:0];
  assign qk32  = 32'(qk);
  assign q_out = {q_r[RW-1:KEY_BITS], qk32[15:0]};

  // Level parity is the parity of the position of the leading one of n+1.
  always_comb begin
    lvl_odd = 1'b0;
    for (int i = 0; i <= AW; i++) begin
      if (v_w[i]) lvl_odd = i[0];
    end
    on_min = !lvl_odd;
  end

  always_comb begin
    case (kind_r)
      K_PAR:   move = qk > key_r;
      K_FIRST: move = on_min ? (key_r > qk) : (key_r < qk);
      K_GP:    move = less_r ? (key_r < qk) : (key_r > qk);
      default: move = 1'b0;
    endcase
    n_nxt = n_r;
    kind_nxt = kind_r;
    less_nxt = less_r;
    step_cont = 1'b0;
    if (move) begin
      n_nxt = anc;
      if (kind_r == K_FIRST) begin
        kind_nxt = K_GP;
        less_nxt = !on_min;
      end
      step_cont = has_anc(anc, kind_nxt);
    end else if (kind_r == K_FIRST) begin
      // New node stays on its own path and climbs by grandparents.
      kind_nxt = K_GP;
      less_nxt = on_min;
      step_cont = has_anc(n_r, K_GP);
    end
  end

  // The leftmost node of the bottom level is the count with all bits below its
  // leading one set, shifted down by one.
  always_comb begin
    smear = count_r;
    for (int s = 1; s < CW; s = s * 2) begin
      smear = smear | (smear >> s);
    end
    last_w = count_r - CW'(1);
  end

  always_comb begin
    raddr = '0;
    if (cmd.rd_anc) raddr = anc;
    else if (cmd.rd_root) raddr = '0;
    else if (cmd.rd_last) raddr = last_w[AW-1:0];
    else if (cmd.rd_left) raddr = AW'(smear >> 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_final) begin
      mem[n_r] <= {id_r, key_r};
    end else if (cmd.step && move) begin
      mem[n_r] <= q_r;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= '0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (cmd.start && !stat.start_ovf) count_r <= count_eff + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r    <= count_eff[AW-1:0];
      id_r   <= in_word.record_id;
      key_r  <= key_in;
      kind_r <= mode_r ? K_FIRST : K_PAR;
      less_r <= 1'b0;
      ovf_r  <= stat.start_ovf;
    end else if (cmd.step) begin
      n_r    <= n_nxt;
      kind_r <= kind_nxt;
      less_r <= less_nxt;
    end
    if (cmd.cap_root) root_r <= q_out;
    if (cmd.cap_last) last_r <= q_out;
    if (cmd.cap_left) left_r <= q_out;
    if (cmd.load_out) begin
      out_r <= {11'(count_r), ovf_r, root_r, last_r, left_r};
    end
  end

  assign out_word = out_r;

endmodule

>>> sv/mmh_ctrl.sv
// Controller of the heap-insert block: sequences sift steps, the final write
// and the three result reads, and owns both handshakes. Depends on mmh_pkg.
module mmh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mmh_pkg::stat_t stat,
  output mmh_pkg::cmd_t  cmd
);
  import mmh_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (stat.start_ovf) state_nxt = S_RD0;
          else if (stat.start_cont) state_nxt = S_RD;
          else state_nxt = S_WR;
        end
      end
      S_RD: begin
        cmd.rd_anc = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.step = 1'b1;
        state_nxt = stat.step_cont ? S_RD : S_WR;
      end
      S_WR: begin
        cmd.wr_final = 1'b1;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        cmd.rd_root = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.cap_root = 1'b1;
        cmd.rd_last = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.cap_last = 1'b1;
        cmd.rd_left = 1'b1;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        cmd.cap_left = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("controller stayed idle after taking a word");
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_RD))
    else $error("compare without a preceding ancestor read");
  a_rd3_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD3) |=> (state_r == S_OUT))
    else $error("result reads did not end in output state");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

>>> sv/min_or_min_max_heap_insert.sv
// Each accepted word, unless the heap is full, appends (record_id, new_key) to
// an array heap held in one memory and sifts it up, as a plain min heap
// (heap_mode 0) or a min-max heap (heap_mode 1); clear_first empties the heap
// first. One word is worked at a time. Every ancestor compare is a memory read,
// then a compare and move down of the ancestor, with at most log2 HEAP_DEPTH
// compares per word; they are followed by one write and the result reads
// through the single memory port. The result register lets the next word be
// taken while a result still waits. Top level; depends on mmh_pkg, mmh_ctrl,
// mmh_dpath.
module min_or_min_max_heap_insert #(
  parameter int HEAP_DEPTH = 1024,
  parameter int KEY_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmh_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mmh_pkg::out_word_t out_word
);
  import mmh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmh_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .cmd         (cmd),
    .stat        (stat),
    .out_word    (out_word)
  );

endmodule

>>> tb/min_or_min_max_heap_insert_tb.sv
// Testbench for the heap-insert block: a scoreboard class models the heap and
// checks every result word in order. Depends on mmh_pkg and min_or_min_max_heap_insert.
module min_or_min_max_heap_insert_tb;
  import mmh_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 40;
  localparam bit MODE_MIN   = 1'b0;
  localparam bit MODE_MINMAX = 1'b1;

  class heap_scoreboard;
    logic [15:0] ids [DEPTH];
    logic [15:0] keys [DEPTH];
    int          count;
    bit          minmax;
    out_word_t   pending_q [$];
    int          errors;

    function new();
      count = 0;
      minmax = MODE_MIN;
      errors = 0;
    endfunction

    function void swap_nodes(int a, int b);
      logic [15:0] t;
      t = ids[a];  ids[a] = ids[b];  ids[b] = t;
      t = keys[a]; keys[a] = keys[b]; keys[b] = t;
    endfunction

    function bit is_min_level(int n);
      int v;
      int d;
      v = n + 1;
      d = 0;
      while (v > 1) begin
        v = v >> 1;
        d++;
      end
      return (d % 2) == 0;
    endfunction

    function void climb_by_grandparent(int n, bit want_less);
      int g;
      bit move;
      while (n >= 3) begin
        g = ((n - 1) / 2 - 1) / 2;
        move = want_less ? (keys[n] < keys[g]) : (keys[n] > keys[g]);
        if (!move) break;
        swap_nodes(g, n);
        n = g;
      end
    endfunction

    function void sift_up(int n);
      int p;
      if (!minmax) begin
        while (n > 0) begin
          p = (n - 1) / 2;
          if (keys[p] <= keys[n]) break;
          swap_nodes(p, n);
          n = p;
        end
      end else if (n > 0) begin
        p = (n - 1) / 2;
        if (is_min_level(n)) begin
          if (keys[n] > keys[p]) begin
            swap_nodes(n, p);
            climb_by_grandparent(p, 1'b0);
          end else begin
            climb_by_grandparent(n, 1'b1);
          end
        end else begin
          if (keys[n] < keys[p]) begin
            swap_nodes(n, p);
            climb_by_grandparent(p, 1'b1);
          end else begin
            climb_by_grandparent(n, 1'b0);
          end
        end
      end
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      int last;
      int j;
      r = '0;
      if (w.clear_first) count = 0;
      if (count >= DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        ids[count] = w.record_id;
        keys[count] = w.new_key;
        count++;
        sift_up(count - 1);
      end
      r.entry_count = count[10:0];
      if (count > 0) begin
        last = count - 1;
        // Leftmost node of the deepest level: follow left children down.
        j = 0;
        while (2 * j + 1 <= last) j = 2 * j + 1;
        r.root_id = ids[0];
        r.root_key = keys[0];
        r.bottom_id = ids[last];
        r.bottom_key = keys[last];
        r.leftmost_id = ids[j];
        r.leftmost_key = keys[j];
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void compare_field(string name, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %0h", $time, got);
        return;
      end
      e = pending_q.pop_front();
      compare_field("entry_count", e.entry_count, got.entry_count);
      compare_field("overflow", e.overflow, got.overflow);
      compare_field("root_id", e.root_id, got.root_id);
      compare_field("root_key", e.root_key, got.root_key);
      compare_field("bottom_id", e.bottom_id, got.bottom_id);
      compare_field("bottom_key", e.bottom_key, got.bottom_key);
      compare_field("leftmost_id", e.leftmost_id, got.leftmost_id);
      compare_field("leftmost_key", e.leftmost_key, got.leftmost_key);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  heap_scoreboard sb;
  int  cycles;
  int  results_seen;
  bit  long_hold_done;

  min_or_min_max_heap_insert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_word);
      results_seen <= results_seen + 1;
    end
  end

  // Receiver: random stalls, with one long hold once traffic is flowing.
  initial begin
    int n;
    out_stall = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen > 150) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        n = 0;
        while (n < 300) begin
          @(negedge clk);
          n++;
        end
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  end

  task automatic send_word(in_word_t w);
    int g;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_word <= in_word_t'(33'({$urandom, $urandom}));
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_fields(bit clr, logic [15:0] id, logic [15:0] key);
    in_word_t w;
    w.clear_first = clr;
    w.record_id = id;
    w.new_key = key;
    send_word(w);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.minmax = m;
  endtask

  // Mostly growing heaps with random content; a clear now and then.
  task automatic random_run(int n, int clear_odds);
    repeat (n) begin
      send_fields($urandom_range(0, clear_odds - 1) == 0, 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                              : 16'($urandom));
    end
  endtask

  task automatic directed_set();
    send_fields(1'b1, 16'h0000, 16'hFFFF);
    send_fields(1'b0, 16'hFFFF, 16'h0000);
    send_fields(1'b0, 16'h1234, 16'h8000);
    send_fields(1'b0, 16'h0001, 16'h8000);
    send_fields(1'b0, 16'h0002, 16'h0000);
    send_fields(1'b0, 16'hAAAA, 16'hFFFF);
    send_fields(1'b0, 16'h5555, 16'h7FFF);
    send_fields(1'b0, 16'h0003, 16'h0001);
    send_fields(1'b0, 16'h0004, 16'hFFFE);
    send_fields(1'b1, 16'h8001, 16'h4000);
    send_fields(1'b1, 16'h8002, 16'h4000);
    send_fields(1'b0, 16'h8003, 16'h4000);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    results_seen = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_MIN);
    directed_set();
    random_run(150, 60);
    write_mode(MODE_MINMAX);
    directed_set();
    random_run(150, 60);

    // Fill the heap to capacity, then push words into a full heap.
    send_fields(1'b1, 16'($urandom), 16'($urandom));
    random_run(DEPTH - 1, 1000000);
    repeat (4) send_fields(1'b0, 16'($urandom), 16'($urandom));
    drain();

    // Switch to plain min heap with records held, then overflow again.
    write_mode(MODE_MIN);
    repeat (2) send_fields(1'b0, 16'($urandom), 16'($urandom));
    send_fields(1'b1, 16'hFFFF, 16'hFFFF);
    random_run(120, 40);
    write_mode(MODE_MINMAX);
    random_run(60, 1000000);
    write_mode(MODE_MIN);
    random_run(60, 30);

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
